// ----- design/semantic_class_count_update_core_macros.svh -----
// Assertion macros shared by the semantic class count update design.
`ifndef SEMANTIC_CLASS_COUNT_UPDATE_CORE_MACROS_SVH
`define SEMANTIC_CLASS_COUNT_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SEMCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SEMCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/semcc_pkg.sv -----
// Types and constants shared by the semantic class count update design.
package semcc_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int SEM_W       = 2;
  localparam int COUNT_W     = 32;
  localparam int YBAR_W      = 24;
  localparam int THR_W       = 16;
  localparam int FRAC_W      = 16;
  localparam int SUM_W       = COUNT_W + CLS_W;
  localparam int PROD_W      = SUM_W + THR_W;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_OCC_THR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FREE_THR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PRIOR    = 2'd2;

  localparam logic [THR_W-1:0]   OCC_THR_RST  = 16'd45875;
  localparam logic [THR_W-1:0]   FREE_THR_RST = 16'd19661;
  localparam logic [COUNT_W-1:0] PRIOR_RST    = 32'd32768;

  typedef enum logic [1:0] {
    OCC_FREE     = 2'd0,
    OCC_OCCUPIED = 2'd1,
    OCC_UNKNOWN  = 2'd2
  } occ_state_t;

  typedef struct packed {
    logic [THR_W-1:0] occ_thr;
    logic [THR_W-1:0] free_thr;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               sat;
  } lane_out_t;

  typedef struct packed {
    logic [CLS_W-1:0] best;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] rest;
    logic             sat;
  } s2_t;

endpackage

// ----- design/semcc_lane.sv -----
// One class lane: holds the class count and adds the increment with saturation.
module semcc_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          restart,
  input  logic [semcc_pkg::YBAR_W-1:0]  ybar,
  input  logic [semcc_pkg::COUNT_W-1:0] prior,
  output semcc_pkg::lane_out_t          lane_o
);
  import semcc_pkg::*;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W:0]   total;
  logic               sat_r;
  logic               sat_nxt;

  always_comb begin
    base      = restart ? prior : count_r;
    total     = (COUNT_W + 1)'(base) + (COUNT_W + 1)'(ybar);
    sat_nxt   = total[COUNT_W];
    count_nxt = sat_nxt ? {COUNT_W{1'b1}} : total[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sat_r   <= 1'b0;
    end else if (en) begin
      count_r <= count_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign lane_o.count = count_r;
  assign lane_o.sat   = sat_r;

endmodule

// ----- design/semcc_merge.sv -----
// Merging pipeline: argmax and sum over the lanes, threshold products, occupancy decision.
module semcc_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  output logic                            take,
  input  semcc_pkg::lane_out_t            lanes [semcc_pkg::NUM_CLASSES],
  input  semcc_pkg::cfg_t                 thr,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [semcc_pkg::SEM_W-1:0]     out_semantic_class,
  output semcc_pkg::occ_state_t           out_occupancy_state,
  output logic                            out_saturated
);
  import semcc_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  s2_t              s2_nxt;
  s2_t              s2_r;
  logic [COUNT_W-1:0] best_val;

  logic [PROD_W-1:0] prod_occ_r;
  logic [PROD_W-1:0] prod_free_r;
  logic [PROD_W-1:0] rest_sh_r;
  logic              free_sel_r;
  logic [CLS_W-1:0]  best3_r;
  logic              sat3_r;

  logic [SEM_W-1:0]  class_r;
  occ_state_t        state_r;
  occ_state_t        state_nxt;
  logic              sat4_r;

  // A stage takes a new transaction when it is empty or its contents move on.
  assign en4  = !v4_r || !out_stall;
  assign en3  = !v3_r || en4;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign take = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= fire;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Argmax keeps the earlier class on ties because only a strictly larger count wins.
  always_comb begin
    best_val    = lanes[0].count;
    s2_nxt.best = '0;
    s2_nxt.sum  = SUM_W'(lanes[0].count);
    s2_nxt.sat  = lanes[0].sat;
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if (lanes[i].count > best_val) begin
        best_val    = lanes[i].count;
        s2_nxt.best = CLS_W'(i);
      end
      s2_nxt.sum = s2_nxt.sum + SUM_W'(lanes[i].count);
      s2_nxt.sat = s2_nxt.sat | lanes[i].sat;
    end
    s2_nxt.rest = s2_nxt.sum - SUM_W'(lanes[0].count);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r <= s2_nxt;
    end
  end

  // p = rest / sum is compared against the thresholds by cross multiplication.
  always_ff @(posedge clk) begin
    if (en3) begin
      prod_occ_r  <= PROD_W'(thr.occ_thr) * PROD_W'(s2_r.sum);
      prod_free_r <= PROD_W'(thr.free_thr) * PROD_W'(s2_r.sum);
      rest_sh_r   <= PROD_W'(s2_r.rest) << FRAC_W;
      free_sel_r  <= (s2_r.best == '0) || (s2_r.sum == '0);
      best3_r     <= s2_r.best;
      sat3_r      <= s2_r.sat;
    end
  end

  always_comb begin
    if (free_sel_r) begin
      state_nxt = OCC_FREE;
    end else if (rest_sh_r > prod_occ_r) begin
      state_nxt = OCC_OCCUPIED;
    end else if (rest_sh_r < prod_free_r) begin
      state_nxt = OCC_FREE;
    end else begin
      state_nxt = OCC_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      class_r <= SEM_W'(best3_r);
      state_r <= state_nxt;
      sat4_r  <= sat3_r;
    end
  end

  assign out_valid           = v4_r;
  assign out_semantic_class  = class_r;
  assign out_occupancy_state = state_r;
  assign out_saturated       = sat4_r;

endmodule

// ----- design/semantic_class_count_update_core.sv -----
// Top level of the semantic class count update core: register port, class lanes, merge.
// A result goes through the lane, argmax, product and compare registers to the output.
// Throughput: one transaction per cycle unless out_stall holds a full pipeline; the
// lanes update the class counts as each item is accepted, and the argmax, sum, product
// and compare stages are pipelined. Reset (synchronous, active low) clears the counts,
// empties the pipeline and loads the register defaults; no clearing pass is needed.
`include "semantic_class_count_update_core_macros.svh"

module semantic_class_count_update_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  input  logic [semcc_pkg::YBAR_W-1:0]      in_ybar_0,
  input  logic [semcc_pkg::YBAR_W-1:0]      in_ybar_1,
  input  logic [semcc_pkg::YBAR_W-1:0]      in_ybar_2,
  input  logic [semcc_pkg::YBAR_W-1:0]      in_ybar_3,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [semcc_pkg::SEM_W-1:0]       out_semantic_class,
  output semcc_pkg::occ_state_t             out_occupancy_state,
  output logic                              out_saturated,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [semcc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [semcc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [semcc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);
  import semcc_pkg::*;

  logic [THR_W-1:0]     occ_thr_r;
  logic [THR_W-1:0]     free_thr_r;
  logic [COUNT_W-1:0]   prior_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                 take;
  logic                 fire;
  cfg_t                 thr;
  logic [YBAR_W-1:0]    ybar [NUM_CLASSES];
  lane_out_t            lanes [NUM_CLASSES];

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_thr_r  <= OCC_THR_RST;
      free_thr_r <= FREE_THR_RST;
      prior_r    <= PRIOR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OCC_THR:  occ_thr_r  <= cfg_pwdata[THR_W-1:0];
        REG_FREE_THR: free_thr_r <= cfg_pwdata[THR_W-1:0];
        REG_PRIOR:    prior_r    <= cfg_pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OCC_THR:  cfg_prdata = CFG_DATA_W'(occ_thr_r);
      REG_FREE_THR: cfg_prdata = CFG_DATA_W'(free_thr_r);
      REG_PRIOR:    cfg_prdata = CFG_DATA_W'(prior_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign thr.occ_thr  = occ_thr_r;
  assign thr.free_thr = free_thr_r;

  assign in_stall = !take;
  assign fire     = in_valid && take;

  assign ybar[0] = in_ybar_0;
  assign ybar[1] = in_ybar_1;
  assign ybar[2] = in_ybar_2;
  assign ybar[3] = in_ybar_3;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_lane
    semcc_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (fire),
      .restart (in_restart),
      .ybar    (ybar[g]),
      .prior   (prior_r),
      .lane_o  (lanes[g])
    );
  end

  semcc_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fire                (fire),
    .take                (take),
    .lanes               (lanes),
    .thr                 (thr),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_semantic_class  (out_semantic_class),
    .out_occupancy_state (out_occupancy_state),
    .out_saturated       (out_saturated)
  );

  // The input side only stalls when every stage is full behind a stalled result.
  `SEMCC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while the result channel is free")
  // A result for class 0 is always free space.
  `SEMCC_ASSERT_NOW(a_class0_free, clk, rst_n, out_valid && (out_semantic_class == '0), out_occupancy_state == OCC_FREE, "class 0 result not reported as free")
  // An accepted transaction with the result side open must not be lost in the pipeline.
  `SEMCC_ASSERT_NEXT(a_pipe_fills, clk, rst_n, in_valid && !in_stall, !in_stall || out_valid, "accepted transaction vanished from the pipeline")

endmodule
